/* rtl/sh9_pkg.sv */
// Shared types, constants and helper functions for the SH9 irradiance block.
package sh9_pkg;

  localparam int DirW   = 16;
  localparam int OutW   = 40;
  localparam int BasisW = 16;
  localparam int MulW   = 34;
  localparam int ProdW  = 2 * MulW;

  // Basis and band constants, Q2.14.
  localparam int KB0    = 4622;
  localparam int KB1    = 8005;
  localparam int KB2    = 17900;
  localparam int KB6    = 5167;
  localparam int KB8    = 8950;
  localparam int BandPi = 51472;
  localparam int Band1  = 34315;
  localparam int Band2  = 12868;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_EVAL  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_NORM_START,
    ST_NORM_WAIT,
    ST_B_MUL,
    ST_B_WB,
    ST_S_MUL,
    ST_S_WB,
    ST_A_MUL,
    ST_A_WB,
    ST_E_MMUL,
    ST_E_MWB,
    ST_E_LMUL,
    ST_E_LWB,
    ST_E_HMUL,
    ST_E_HWB,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_DIV,
    DS_SQRT
  } ds_phase_e;

  typedef logic signed [BasisW-1:0] basis_t;
  typedef logic signed [MulW-1:0]   mul_op_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  // Round half toward plus infinity, then drop the low bits.
  function automatic prod_t rnd_shift(input prod_t p, input int s);
    prod_t half;
    half = ProdW'(1) <<< (s - 1);
    return (p + half) >>> s;
  endfunction

  function automatic mul_op_t band_factor(input logic [3:0] idx);
    mul_op_t f;
    case (idx)
      4'd0:                      f = MulW'(BandPi);
      4'd1, 4'd2, 4'd3:          f = MulW'(Band1);
      default:                   f = MulW'(Band2);
    endcase
    return f;
  endfunction

endpackage

/* rtl/sh9_if.sv */
// Channel interfaces for the SH9 irradiance block.
interface sh9_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic signed [15:0] sample_value;
  logic [15:0] sample_weight;

  modport source (output valid, action, dir_x, dir_y, dir_z, sample_value, sample_weight,
                  input ready);
  modport sink   (input valid, action, dir_x, dir_y, dir_z, sample_value, sample_weight,
                  output ready);
endinterface

interface sh9_out_if;
  logic        valid;
  logic        ready;
  logic signed [39:0] irradiance;

  modport source (output valid, irradiance, input ready);
  modport sink   (input valid, irradiance, output ready);
endinterface

/* rtl/sh9_mul.sv */
// Shared signed multiplier with a registered product.
module sh9_mul import sh9_pkg::*; (
  input  logic    clk_i,
  input  mul_op_t a_i,
  input  mul_op_t b_i,
  output prod_t   p_o
);

  prod_t p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

/* rtl/sh9_divsqrt.sv */
// Bit-serial unit: floor(num * 2^32 / den), then integer square root of the quotient.
module sh9_divsqrt import sh9_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [16:0] root_o
);

  ds_phase_e   phase_q;
  logic [5:0]  cnt_q;
  logic [32:0] rem_q;
  logic [32:0] quo_q;
  logic [34:0] root_q;
  logic [32:0] bit_q;
  logic [31:0] den_q;
  logic        lsb_q;

  logic [33:0] rem_sh;
  logic [34:0] op_a;
  logic [34:0] op_b;
  logic [35:0] diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, (cnt_q == 6'd32) ? lsb_q : 1'b0};
    if (phase_q == DS_SQRT) begin
      op_a = {2'b00, quo_q};
      op_b = root_q + {2'b00, bit_q};
    end else begin
      op_a = {1'b0, rem_sh};
      op_b = {3'b000, den_q};
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = ~diff[35];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= DS_IDLE;
      cnt_q   <= '0;
    end else begin
      case (phase_q)
        DS_IDLE: begin
          if (start_i) begin
            phase_q <= DS_DIV;
            cnt_q   <= 6'd32;
          end
        end
        DS_DIV: begin
          if (cnt_q == '0) begin
            phase_q <= DS_SQRT;
            cnt_q   <= 6'd16;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        DS_SQRT: begin
          if (cnt_q == '0) begin
            phase_q <= DS_IDLE;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        default: phase_q <= DS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      DS_IDLE: begin
        if (start_i) begin
          rem_q <= {3'b000, num_i[30:1]};
          lsb_q <= num_i[0];
          den_q <= den_i;
          quo_q <= '0;
        end
      end
      DS_DIV: begin
        rem_q <= ge ? diff[32:0] : rem_sh[32:0];
        quo_q <= {quo_q[31:0], ge};
        if (cnt_q == '0) begin
          root_q <= '0;
          bit_q  <= 33'h1_0000_0000;
        end
      end
      DS_SQRT: begin
        if (ge) begin
          quo_q  <= diff[32:0];
          root_q <= (root_q >> 1) + {2'b00, bit_q};
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: ;
    endcase
  end

  assign busy_o = (phase_q != DS_IDLE);
  assign root_o = root_q[16:0];

endmodule

/* rtl/sh9_projection_irradiance.sv */
// Top level: order-2 spherical harmonic accumulator and irradiance evaluator.
//
//  channel  dir  payload                                              words
//  in_i     in   action, dir_x/y/z, sample_value, sample_weight        one per operation
//  out_o    out  irradiance (signed, 16 fraction bits)                one per evaluate
//
// For an add or an evaluate with a nonzero direction, each of the three direction
// components goes through a 50-step divide and square root unit, and every product
// goes through the single shared multiplier. Reset clears the coefficients and the
// sequencer. Input is not ready while a word is being worked on; a finished irradiance
// waits in the output register until taken.
module sh9_projection_irradiance import sh9_pkg::*; #(
  parameter int COEFF_WIDTH = 40
) (
  input  logic clk_i,
  input  logic rst_ni,
  sh9_in_if.sink    in_i,
  sh9_out_if.source out_o
);

  localparam int AccW = COEFF_WIDTH + 36;
  localparam int RndW = AccW - 28;

  state_e state_q, state_d;
  logic [3:0] cnt_q;
  logic [1:0] ci;

  logic signed [COEFF_WIDTH-1:0] coef_q [9];
  basis_t                        b_q [9];
  logic signed [DirW-1:0]        d_q [3];
  logic signed [DirW-1:0]        u_q [3];
  logic [30:0]                   a2_q [3];
  logic [31:0]                   len2_q;
  logic [1:0]                    act_q;
  logic signed [DirW-1:0]        val_q;
  logic [15:0]                   wgt_q;
  mul_op_t                       t_q, s_q, m_q;
  logic signed [AccW-1:0]        acc_q;
  logic                          out_valid_q;
  logic signed [OutW-1:0]        irr_q;

  mul_op_t mul_a, mul_b;
  prod_t   prod;

  logic        ds_start, ds_busy;
  logic [16:0] ds_root;
  logic [17:0] n_full;
  logic signed [DirW-1:0] n_mag;

  logic signed [63:0]            c64;
  logic signed [COEFF_WIDTH:0]   csum;
  logic signed [COEFF_WIDTH-1:0] csat;
  prod_t                         padd;
  logic signed [AccW-1:0]        acc_r;
  logic signed [RndW-1:0]        rnd_v;
  logic signed [OutW-1:0]        irr_sat;
  logic                          in_fire, out_free;

  assign ci       = cnt_q[1:0];
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  sh9_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  sh9_divsqrt u_divsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ds_start),
    .num_i   (a2_q[ci]),
    .den_i   (len2_q),
    .busy_o  (ds_busy),
    .root_o  (ds_root)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    c64   = 64'(coef_q[cnt_q]);
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ_MUL: begin
        mul_a = MulW'(d_q[ci]);
        mul_b = MulW'(d_q[ci]);
      end
      ST_B_MUL: begin
        case (cnt_q)
          4'd0:  begin mul_a = MulW'(KB1); mul_b = MulW'(u_q[1]); end
          4'd1:  begin mul_a = MulW'(KB1); mul_b = MulW'(u_q[2]); end
          4'd2:  begin mul_a = MulW'(KB1); mul_b = MulW'(u_q[0]); end
          4'd3:  begin mul_a = MulW'(u_q[0]); mul_b = MulW'(u_q[1]); end
          4'd5:  begin mul_a = MulW'(u_q[1]); mul_b = MulW'(u_q[2]); end
          4'd7:  begin mul_a = MulW'(u_q[2]); mul_b = MulW'(u_q[2]); end
          4'd8:  begin mul_a = MulW'(KB6); mul_b = t_q; end
          4'd9:  begin mul_a = MulW'(u_q[0]); mul_b = MulW'(u_q[2]); end
          4'd11: begin mul_a = MulW'(u_q[0]); mul_b = MulW'(u_q[0]); end
          4'd12: begin mul_a = MulW'(u_q[1]); mul_b = MulW'(u_q[1]); end
          4'd13: begin mul_a = MulW'(KB8); mul_b = t_q; end
          default: begin mul_a = MulW'(KB2); mul_b = t_q; end
        endcase
      end
      ST_S_MUL: begin
        mul_a = MulW'(val_q);
        mul_b = MulW'({1'b0, wgt_q});
      end
      ST_A_MUL: begin
        mul_a = s_q;
        mul_b = MulW'(b_q[cnt_q]);
      end
      ST_E_MMUL: begin
        mul_a = band_factor(cnt_q);
        mul_b = MulW'(b_q[cnt_q]);
      end
      ST_E_LMUL: begin
        mul_a = {2'b00, c64[31:0]};
        mul_b = m_q;
      end
      ST_E_HMUL: begin
        mul_a = MulW'($signed(c64[63:32]));
        mul_b = m_q;
      end
      default: ;
    endcase
  end

  // Unit component from the root, coefficient update and output rounding.
  always_comb begin
    n_full = ({1'b0, ds_root} + 18'd1) >> 1;
    n_mag  = (n_full > 18'd32767) ? DirW'(32767) : DirW'(n_full);

    padd = rnd_shift(prod, 21);
    csum = (COEFF_WIDTH + 1)'(coef_q[cnt_q]) + (COEFF_WIDTH + 1)'(padd);
    if (csum[COEFF_WIDTH] != csum[COEFF_WIDTH-1]) begin
      csat = csum[COEFF_WIDTH] ? {1'b1, {(COEFF_WIDTH-1){1'b0}}}
                               : {1'b0, {(COEFF_WIDTH-1){1'b1}}};
    end else begin
      csat = csum[COEFF_WIDTH-1:0];
    end

    acc_r = acc_q + (AccW'(1) <<< 27);
    rnd_v = RndW'(acc_r >>> 28);
    if (&rnd_v[RndW-1:OutW-1] || ~|rnd_v[RndW-1:OutW-1]) begin
      irr_sat = rnd_v[OutW-1:0];
    end else if (rnd_v[RndW-1]) begin
      irr_sat = {1'b1, {(OutW-1){1'b0}}};
    end else begin
      irr_sat = {1'b0, {(OutW-1){1'b1}}};
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_d  = state_q;
    ds_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.action == ACT_ADD || in_i.action == ACT_EVAL)) begin
          state_d = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: state_d = ST_SQ_ACC;
      ST_SQ_ACC: state_d = (ci == 2'd2) ? ST_NORM_START : ST_SQ_MUL;
      ST_NORM_START: begin
        if (len2_q == '0) begin
          state_d = (ci == 2'd2) ? ST_B_MUL : ST_NORM_START;
        end else begin
          ds_start = 1'b1;
          state_d  = ST_NORM_WAIT;
        end
      end
      ST_NORM_WAIT: begin
        if (!ds_busy) begin
          state_d = (ci == 2'd2) ? ST_B_MUL : ST_NORM_START;
        end
      end
      ST_B_MUL: state_d = ST_B_WB;
      ST_B_WB: begin
        if (cnt_q == 4'd13) begin
          state_d = (act_q == ACT_ADD) ? ST_S_MUL : ST_E_MMUL;
        end else begin
          state_d = ST_B_MUL;
        end
      end
      ST_S_MUL:  state_d = ST_S_WB;
      ST_S_WB:   state_d = ST_A_MUL;
      ST_A_MUL:  state_d = ST_A_WB;
      ST_A_WB:   state_d = (cnt_q == 4'd8) ? ST_IDLE : ST_A_MUL;
      ST_E_MMUL: state_d = ST_E_MWB;
      ST_E_MWB:  state_d = ST_E_LMUL;
      ST_E_LMUL: state_d = ST_E_LWB;
      ST_E_LWB:  state_d = ST_E_HMUL;
      ST_E_HMUL: state_d = ST_E_HWB;
      ST_E_HWB:  state_d = (cnt_q == 4'd8) ? ST_FINISH : ST_E_MMUL;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state: counter, coefficients and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 9; i++) coef_q[i] <= '0;
    end else begin
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_fire && in_i.action == ACT_CLEAR) begin
            for (int i = 0; i < 9; i++) coef_q[i] <= '0;
          end
        end
        ST_SQ_ACC, ST_NORM_WAIT: begin
          if (state_q == ST_SQ_ACC || !ds_busy) begin
            cnt_q <= (ci == 2'd2) ? 4'd0 : cnt_q + 4'd1;
          end
        end
        ST_NORM_START: begin
          if (len2_q == '0) cnt_q <= (ci == 2'd2) ? 4'd0 : cnt_q + 4'd1;
        end
        ST_B_WB:  cnt_q <= (cnt_q == 4'd13) ? 4'd0 : cnt_q + 4'd1;
        ST_S_WB:  cnt_q <= '0;
        ST_A_WB: begin
          coef_q[cnt_q] <= csat;
          cnt_q         <= cnt_q + 4'd1;
        end
        ST_E_HWB: cnt_q <= cnt_q + 4'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          act_q  <= in_i.action;
          d_q[0] <= in_i.dir_x;
          d_q[1] <= in_i.dir_y;
          d_q[2] <= in_i.dir_z;
          val_q  <= in_i.sample_value;
          wgt_q  <= in_i.sample_weight;
          len2_q <= '0;
          acc_q  <= '0;
          b_q[0] <= BasisW'(KB0);
        end
      end
      ST_SQ_ACC: begin
        a2_q[ci] <= prod[30:0];
        len2_q   <= len2_q + prod[31:0];
      end
      ST_NORM_START: begin
        if (len2_q == '0) u_q[ci] <= '0;
      end
      ST_NORM_WAIT: begin
        if (!ds_busy) u_q[ci] <= d_q[ci][DirW-1] ? -n_mag : n_mag;
      end
      ST_B_WB: begin
        case (cnt_q)
          4'd0:  b_q[1] <= BasisW'(rnd_shift(prod, 15));
          4'd1:  b_q[2] <= BasisW'(rnd_shift(prod, 15));
          4'd2:  b_q[3] <= BasisW'(rnd_shift(prod, 15));
          4'd4:  b_q[4] <= BasisW'(rnd_shift(prod, 30));
          4'd6:  b_q[5] <= BasisW'(rnd_shift(prod, 30));
          4'd7:  t_q    <= (MulW'(prod) <<< 1) + MulW'(prod) - (MulW'(1) <<< 30);
          4'd8:  b_q[6] <= BasisW'(rnd_shift(prod, 30));
          4'd10: b_q[7] <= BasisW'(rnd_shift(prod, 30));
          4'd12: t_q    <= t_q - MulW'(prod);
          4'd13: b_q[8] <= BasisW'(rnd_shift(prod, 30));
          default: t_q  <= MulW'(prod);
        endcase
      end
      ST_S_WB:  s_q   <= MulW'(prod);
      ST_E_MWB: m_q   <= MulW'(prod);
      ST_E_LWB: acc_q <= acc_q + AccW'(prod);
      ST_E_HWB: acc_q <= acc_q + (AccW'(prod) <<< 32);
      ST_FINISH: begin
        if (out_free) irr_q <= irr_sat;
      end
      default: ;
    endcase
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.irradiance = irr_q;

endmodule

/* bench/sh9_projection_irradiance_tb.sv */
// Self-checking testbench for the SH9 irradiance accumulator: directed table, then random words.
module sh9_projection_irradiance_tb;
  import sh9_pkg::*;

  localparam int CW = 40;

  typedef struct {
    action_e     act;
    logic signed [15:0] x, y, z, val;
    logic [15:0] wgt;
    bit          has_exp;
    logic signed [39:0] exp_irr;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  sh9_in_if  in_ch();
  sh9_out_if out_ch();

  sh9_projection_irradiance #(.COEFF_WIDTH(CW)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  longint coeff_q[9];
  logic signed [39:0] irr_expected[$];
  int mismatches = 0;
  bit sending_done = 1'b0;

  function automatic longint rshift_rnd(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint isqrt(longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(r);
  endfunction

  // Normalizes the direction to Q1.15 and fills the nine Q2.14 basis values.
  function automatic void sh_basis(longint cx, longint cy, longint cz, ref longint b[9]);
    longint c[3], u[3];
    longint unsigned len2, a, t, n;
    c[0] = cx; c[1] = cy; c[2] = cz;
    len2 = cx * cx + cy * cy + cz * cz;
    for (int i = 0; i < 3; i++) begin
      if (len2 == 0) begin
        u[i] = 0;
      end else begin
        a = c[i] < 0 ? -c[i] : c[i];
        t = isqrt(((a * a) << 32) / len2);
        n = (t + 1) >> 1;
        if (n > 32767) n = 32767;
        u[i] = c[i] < 0 ? -longint'(n) : longint'(n);
      end
    end
    b[0] = KB0;
    b[1] = rshift_rnd(KB1 * u[1], 15);
    b[2] = rshift_rnd(KB1 * u[2], 15);
    b[3] = rshift_rnd(KB1 * u[0], 15);
    b[4] = rshift_rnd(KB2 * (u[0] * u[1]), 30);
    b[5] = rshift_rnd(KB2 * (u[1] * u[2]), 30);
    b[6] = rshift_rnd(KB6 * (3 * u[2] * u[2] - (longint'(1) << 30)), 30);
    b[7] = rshift_rnd(KB2 * (u[0] * u[2]), 30);
    b[8] = rshift_rnd(KB8 * (u[0] * u[0] - u[1] * u[1]), 30);
  endfunction

  // Updates the coefficient copy and returns whether an irradiance word results.
  function automatic bit predict_irradiance(stim_t s, output logic signed [39:0] irr);
    longint b[9], smp, p, hi, lo;
    logic signed [127:0] acc;
    logic signed [127:0] pmax, nmin;
    irr = '0;
    if (s.act == ACT_CLEAR) begin
      foreach (coeff_q[i]) coeff_q[i] = 0;
      return 0;
    end
    if (s.act == ACT_NONE) return 0;
    sh_basis(s.x, s.y, s.z, b);
    if (s.act == ACT_ADD) begin
      smp = longint'(s.val) * longint'({1'b0, s.wgt});
      hi = (longint'(1) << (CW - 1)) - 1;
      lo = -hi - 1;
      for (int i = 0; i < 9; i++) begin
        p = rshift_rnd(smp * b[i], 21);
        if (p > 0 && coeff_q[i] > hi - p) coeff_q[i] = hi;
        else if (p < 0 && coeff_q[i] < lo - p) coeff_q[i] = lo;
        else coeff_q[i] += p;
      end
      return 0;
    end
    acc = 0;
    for (int i = 0; i < 9; i++) begin
      p = (i == 0) ? BandPi : (i < 4) ? Band1 : Band2;
      acc += 128'(coeff_q[i]) * 128'(p * b[i]);
    end
    acc = (acc + (128'sd1 <<< 27)) >>> 28;
    pmax = (128'sd1 <<< 39) - 1;
    nmin = -(128'sd1 <<< 39);
    if (acc > pmax) acc = pmax;
    else if (acc < nmin) acc = nmin;
    irr = acc[39:0];
    return 1;
  endfunction

  function automatic logic signed [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom());
    endcase
  endfunction

  // Idles the input for a random number of cycles; a zero gap keeps valid high.
  task automatic gap(int lo_pct);
    int n;
    n = 0;
    if ($urandom_range(0, 99) < lo_pct) begin
      n = $urandom_range(1, 3);
    end else if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(20, 300);
    end
    if (n != 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drives one word and records the expectation the moment it is accepted.
  task automatic send_word(stim_t s);
    logic signed [39:0] irr;
    in_ch.valid         <= 1'b1;
    in_ch.action        <= s.act;
    in_ch.dir_x         <= s.x;
    in_ch.dir_y         <= s.y;
    in_ch.dir_z         <= s.z;
    in_ch.sample_value  <= s.val;
    in_ch.sample_weight <= s.wgt;
    do @(posedge clk_i); while (!in_ch.ready);
    if (predict_irradiance(s, irr)) begin
      if (s.has_exp && irr != s.exp_irr) begin
        if (mismatches < 10)
          $display("table row disagrees with prediction: expected %0d got %0d",
                   s.exp_irr, irr);
        mismatches++;
      end
      irr_expected.push_back(irr);
    end
  endtask

  function automatic stim_t mk(action_e a, int x, int y, int z, int v, int w,
                               bit he = 0, longint e = 0);
    stim_t s;
    s.act = a; s.x = 16'(x); s.y = 16'(y); s.z = 16'(z); s.val = 16'(v); s.wgt = 16'(w);
    s.has_exp = he; s.exp_irr = 40'(e);
    return s;
  endfunction

  initial begin
    stim_t tbl[$];
    stim_t s;
    int r;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_CLEAR;
    in_ch.dir_x = '0; in_ch.dir_y = '0; in_ch.dir_z = '0;
    in_ch.sample_value = '0; in_ch.sample_weight = '0;
    foreach (coeff_q[i]) coeff_q[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Evaluating fresh coefficients gives zero, also for a zero-length normal.
    tbl.push_back(mk(ACT_EVAL, 0, 0, 1, 0, 0, 1, 0));
    tbl.push_back(mk(ACT_EVAL, 0, 0, 0, 0, 0, 1, 0));
    tbl.push_back(mk(ACT_ADD, 0, 0, 0, 256, 32768));
    tbl.push_back(mk(ACT_EVAL, 0, 0, 0, 0, 0));
    tbl.push_back(mk(ACT_ADD, 32767, 0, 0, 32767, 65535));
    tbl.push_back(mk(ACT_ADD, -32768, -32768, -32768, -32768, 65535));
    tbl.push_back(mk(ACT_EVAL, 1, 1, 1, 0, 0));
    tbl.push_back(mk(ACT_NONE, 5, 5, 5, 100, 100));
    tbl.push_back(mk(ACT_EVAL, -32768, 32767, 0, 0, 0));
    tbl.push_back(mk(ACT_CLEAR, 0, 0, 0, 0, 0));
    tbl.push_back(mk(ACT_EVAL, 0, 32767, 0, 0, 0, 1, 0));
    // Accumulate large positive, then large negative samples along the z axis.
    for (int i = 0; i < 5; i++) tbl.push_back(mk(ACT_ADD, 0, 0, 32767, 32767, 65535));
    tbl.push_back(mk(ACT_EVAL, 0, 0, 32767, 0, 0));
    tbl.push_back(mk(ACT_CLEAR, 0, 0, 0, 0, 0));
    for (int i = 0; i < 5; i++) tbl.push_back(mk(ACT_ADD, 0, 0, -32768, -32768, 65535));
    tbl.push_back(mk(ACT_EVAL, 0, 0, -1, 0, 0));
    tbl.push_back(mk(ACT_EVAL, 3, -4, 12, 0, 0));
    foreach (tbl[i]) begin
      send_word(tbl[i]);
      gap(70);
    end

    for (int n = 0; n < 1200; n++) begin
      r = $urandom_range(0, 99);
      s = mk(r < 3 ? ACT_CLEAR : r < 6 ? ACT_NONE : r < 60 ? ACT_ADD : ACT_EVAL,
             rnd16(), rnd16(), rnd16(), rnd16(), 0);
      s.wgt = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom());
      send_word(s);
      gap(60);
    end
    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Result side: random back-pressure and in-order comparison.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (irr_expected.size() == 0) begin
          if (mismatches < 10) $display("unexpected irradiance word %0d", out_ch.irradiance);
          mismatches++;
        end else begin
          if (out_ch.irradiance !== irr_expected[0]) begin
            if (mismatches < 10)
              $display("irradiance mismatch: expected %0d got %0d",
                       irr_expected[0], out_ch.irradiance);
            mismatches++;
          end
          void'(irr_expected.pop_front());
        end
      end
      if ($urandom_range(0, 39) == 0) out_ch.ready <= 1'b0;
      else if ($urandom_range(0, 2) != 0) out_ch.ready <= 1'b1;
    end
  end

  initial begin
    wait (sending_done);
    while (irr_expected.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && irr_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
